// ----- rtl/core/dq_pkg.sv -----
// Package for the double-ended queue: command and status codes, controller states
// and default sizes. It has no dependencies and is used by the top level, the controller and the checker.
package dq_pkg;

  localparam int DQ_DEPTH     = 16;
  localparam int DQ_WORD_BITS = 32;
  localparam int CMD_BITS     = 3;
  localparam int STATUS_BITS  = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_OVER  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DUMP
  } state_t;

endpackage

// ----- rtl/core/double_ended_queue_top.sv -----
// Double-ended queue top level: push, error and unused-code results appear in the cycle after
// the transaction; pop and first dump word pass the registered ring-memory read and then the
// output register, then one dump word per cycle while out_tready does not stall the output.
// A new command is taken only when the previous one has placed its last result.
// Synchronous active-low reset empties the queue at once; ring contents are not cleared.
// Depends on dq_pkg, dq_ram and dq_ctrl.
module double_ended_queue_top #(
  parameter int DEPTH     = dq_pkg::DQ_DEPTH,
  parameter int WORD_BITS = dq_pkg::DQ_WORD_BITS,
  parameter int IN_TDATA_W  = ((WORD_BITS + 7) / 8) * 8,
  parameter int OUT_TDATA_W = ((WORD_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_TDATA_W-1:0]          in_tdata,   // push_value
  input  logic [dq_pkg::CMD_BITS-1:0]    in_tuser,   // cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_TDATA_W-1:0]         out_tdata,  // word, occupancy
  output logic [dq_pkg::STATUS_BITS-1:0] out_tuser,  // status
  output logic                           out_tlast
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] out_word;
  logic [CW-1:0]        out_occ;

  dq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata[WORD_BITS-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dq_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (out_word),
    .out_occ    (out_occ),
    .out_status (out_tuser),
    .out_tlast  (out_tlast),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  assign out_tdata = OUT_TDATA_W'({out_occ, out_word});

endmodule

// ----- rtl/core/dq_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// It has no dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/dq_ctrl.sv -----
// Controller of the double-ended queue: head pointer, fill count, command sequencing,
// ring memory addressing and the output register. Depends on dq_pkg.
module dq_ctrl #(
  parameter int DEPTH     = dq_pkg::DQ_DEPTH,
  parameter int WORD_BITS = dq_pkg::DQ_WORD_BITS,
  parameter int AW        = $clog2(DEPTH),
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [dq_pkg::CMD_BITS-1:0] in_cmd,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [WORD_BITS-1:0]        out_word,
  output logic [CW-1:0]               out_occ,
  output logic [dq_pkg::STATUS_BITS-1:0] out_status,
  output logic                        out_tlast,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  input  logic [WORD_BITS-1:0]        ram_rdata
);
  import dq_pkg::*;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_word_r;
  logic [CW-1:0]        out_occ_r;
  status_t              out_status_r;
  logic                 out_last_r;

  logic                 out_free;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 dump_last;
  cmd_t                 cmd;
  logic                 emit;
  logic [WORD_BITS-1:0] e_word;
  status_t              e_status;
  logic                 e_last;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= (AW+1)'(DEPTH)) ? s - (AW+1)'(DEPTH) : s;
    return t[AW-1:0];
  endfunction

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_cmd);
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign dump_last = (({1'b0, idx_r} + (AW+1)'(1)) == (AW+1)'(count_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !empty) begin
          if (cmd == CMD_POP_FRONT || cmd == CMD_POP_REAR) begin
            state_nxt = ST_POP;
          end else if (cmd == CMD_DUMP) begin
            state_nxt = ST_DUMP;
          end
        end
      end
      ST_POP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free && dump_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_re    = 1'b0;
    ram_raddr = head_r;
    emit      = 1'b0;
    e_word    = '0;
    e_status  = STAT_OK;
    e_last    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUSH_FRONT: begin
              emit = 1'b1;
              if (full) begin
                e_status = STAT_OVER;
              end else begin
                head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
                ram_we    = 1'b1;
                ram_waddr = head_nxt;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_PUSH_REAR: begin
              emit = 1'b1;
              if (full) begin
                e_status = STAT_OVER;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap({1'b0, head_r} + (AW+1)'(count_r));
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = STAT_UNDER;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                head_nxt  = wrap({1'b0, head_r} + (AW+1)'(1));
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_POP_REAR: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = STAT_UNDER;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = wrap({1'b0, head_r} + (AW+1)'(count_r - CW'(1)));
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                idx_nxt   = '0;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          emit   = 1'b1;
          e_word = ram_rdata;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          emit   = 1'b1;
          e_word = ram_rdata;
          e_last = dump_last;
          if (!dump_last) begin
            idx_nxt   = idx_r + AW'(1);
            ram_re    = 1'b1;
            ram_raddr = wrap({1'b0, head_r} + {1'b0, idx_nxt});
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r   <= e_word;
      out_status_r <= e_status;
      out_last_r   <= e_last;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_word   = out_word_r;
  assign out_occ    = out_occ_r;
  assign out_status = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/dq_chk.sv -----
// Port-level checker for the double-ended queue, bound to double_ended_queue_top.
// Depends on dq_pkg.
module dq_chk #(
  parameter int DEPTH       = dq_pkg::DQ_DEPTH,
  parameter int WORD_BITS   = dq_pkg::DQ_WORD_BITS,
  parameter int OUT_TDATA_W = ((WORD_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [OUT_TDATA_W-1:0]         out_tdata,
  input logic [dq_pkg::STATUS_BITS-1:0] out_tuser,
  input logic                           out_tlast
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] occ;
  assign occ = out_tdata[WORD_BITS +: CW];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output transaction changed.");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_OK |-> out_tlast && out_tdata[WORD_BITS-1:0] == '0)
    else $error("Error status without last flag or with nonzero word.");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_EMPTY || out_tuser == STAT_UNDER) |-> occ == '0)
    else $error("Empty or underflow status with nonzero occupancy.");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ <= CW'(DEPTH))
    else $error("Occupancy exceeds depth.");

endmodule

bind double_ended_queue_top dq_chk #(
  .DEPTH       (DEPTH),
  .WORD_BITS   (WORD_BITS),
  .OUT_TDATA_W (OUT_TDATA_W)
) u_dq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
